// File: rtl/tbt_pkg.sv
// Shared types for the triangle tangent and bitangent unit.
`default_nettype none
package tbt_pkg;

  // Q1.14 unit value
  localparam int unsigned OneQ14 = 16384;

  // One triangle as the front end hands it to the back end:
  // edges from corner 0, uv deltas with the v delta negated.
  typedef struct packed {
    logic [2:0][32:0] e1;
    logic [2:0][32:0] e2;
    logic [24:0]      du1;
    logic [24:0]      du2;
    logic [24:0]      dv1;
    logic [24:0]      dv2;
  } tri_t;

endpackage
`default_nettype wire

// File: rtl/tbt_front.sv
// Front end: collects corners and forms edge and uv deltas per triangle.
`default_nettype none
module tbt_front import tbt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [23:0] tex_u,
  input  logic signed [23:0] tex_v,
  input  logic               full,
  output logic               push,
  output tri_t               push_data
);

  logic [1:0]       corner_count;
  logic [2:0][31:0] hp0;
  logic [2:0][31:0] hp1;
  logic [23:0]      hu0, hv0, hu1, hv1;
  logic [2:0][31:0] cur;
  logic             accept;

  assign cur      = {pos_z, pos_y, pos_x};
  assign in_stall = corner_count[1] && full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && corner_count[1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      push_data.e1[i] = 33'($signed(hp1[i])) - 33'($signed(hp0[i]));
      push_data.e2[i] = 33'($signed(cur[i])) - 33'($signed(hp0[i]));
    end
    push_data.du1 = 25'($signed(hu1)) - 25'($signed(hu0));
    push_data.du2 = 25'($signed(tex_u)) - 25'($signed(hu0));
    push_data.dv1 = 25'($signed(hv0)) - 25'($signed(hv1));
    push_data.dv2 = 25'($signed(hv0)) - 25'($signed(tex_v));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_count <= 2'd0;
    end else if (accept) begin
      if (corner_count[1]) begin
        corner_count <= 2'd0;
      end else begin
        corner_count <= corner_count + 2'd1;
      end
    end
  end

  // corner registers; the third corner goes straight into the request
  always_ff @(posedge clk) begin
    if (accept && !corner_count[1]) begin
      if (corner_count[0]) begin
        hp1 <= cur;
        hu1 <= tex_u;
        hv1 <= tex_v;
      end else begin
        hp0 <= cur;
        hu0 <= tex_u;
        hv0 <= tex_v;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/tbt_fifo.sv
// Two-entry queue of triangles between front and back end.
`default_nettype none
module tbt_fifo import tbt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  tri_t push_data,
  output logic full,
  output logic valid,
  input  logic pop,
  output tri_t pop_data
);

  tri_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign valid    = (count != 2'd0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

// File: rtl/tbt_back.sv
// Back end: cross products, magnitude, square root and division per triangle.
`default_nettype none
module tbt_back import tbt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  tri_t               q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] tangent_x,
  output logic signed [15:0] tangent_y,
  output logic signed [15:0] tangent_z,
  output logic signed [15:0] bitangent_x,
  output logic signed [15:0] bitangent_y,
  output logic signed [15:0] bitangent_z,
  output logic               degenerate
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_NINIT, S_NSHIFT, S_SQ, S_SQRT, S_DINIT, S_DIV, S_OUT
  } state_t;

  state_t              state;
  tri_t                tri_r;
  logic [4:0]          k;
  logic [1:0]          c;
  logic                vsel;
  logic signed [57:0]  prod, prev;
  logic                det_zero, det_neg;
  logic signed [57:0]  t_vec [3];
  logic signed [57:0]  b_vec [3];
  logic [56:0]         m [3];
  logic                neg [3];
  logic [59:0]         sq;
  logic [61:0]         sum;
  logic [62:0]         x, r, bitv;
  logic [46:0]         rem;
  logic [48:0]         dsh;
  logic [15:0]         q;
  logic signed [15:0]  res_t [3];
  logic signed [15:0]  res_b [3];
  logic                degen;

  // multiplier operand selection
  logic [2:0]          j;
  logic [2:0]          jr;
  logic [1:0]          ti;
  logic signed [24:0]  mul_a;
  logic signed [32:0]  mul_b;
  logic signed [57:0]  mul_p;
  logic signed [57:0]  diff;

  assign j  = k[3:1];
  assign jr = 3'(k[3:1] - 3'd1);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    ti    = '0;
    priority if (j == 3'd0) begin
      mul_a = k[0] ? $signed(tri_r.du2) : $signed(tri_r.du1);
      mul_b = k[0] ? 33'($signed(tri_r.dv1)) : 33'($signed(tri_r.dv2));
    end else if (j < 3'd4) begin
      ti    = 2'(j - 3'd1);
      mul_a = k[0] ? $signed(tri_r.dv1) : $signed(tri_r.dv2);
      mul_b = k[0] ? $signed(tri_r.e2[ti]) : $signed(tri_r.e1[ti]);
    end else if (j < 3'd7) begin
      ti    = 2'(j - 3'd4);
      mul_a = k[0] ? $signed(tri_r.du2) : $signed(tri_r.du1);
      mul_b = k[0] ? $signed(tri_r.e1[ti]) : $signed(tri_r.e2[ti]);
    end else begin
      mul_a = '0;
    end
  end

  assign mul_p = mul_a * mul_b;
  assign diff  = prev - prod;

  // vector magnitudes for the one being normalized
  logic signed [57:0] nv [3];
  logic [56:0]        nv_mag [3];
  logic               nv_zero;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nv[i]     = vsel ? b_vec[i] : t_vec[i];
      nv_mag[i] = nv[i][57] ? 57'(-nv[i]) : 57'(nv[i]);
    end
    nv_zero = (nv_mag[0] == '0) && (nv_mag[1] == '0) && (nv_mag[2] == '0);
  end

  logic        big;
  logic [61:0] sum_add;
  logic [62:0] trial;
  logic        ge;
  logic [16:0] qn;
  logic [15:0] sat;
  logic [15:0] sval;

  assign big     = (m[0][56:30] != '0) || (m[1][56:30] != '0) || (m[2][56:30] != '0);
  assign sum_add = sum + 62'(sq);
  assign trial   = r + bitv;
  assign ge      = {2'b00, rem} >= dsh;
  assign qn      = {q, ge};
  assign sat     = (qn > 17'(OneQ14)) ? 16'(OneQ14) : 16'(qn);
  assign sval    = neg[0] ? 16'(-sat) : sat;

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            tri_r <= q_data;
            k     <= '0;
            vsel  <= 1'b0;
            degen <= 1'b0;
            for (int i = 0; i < 3; i++) begin
              res_t[i] <= '0;
              res_b[i] <= '0;
            end
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod <= mul_p;
          prev <= prod;
          if (k >= 5'd2 && !k[0]) begin
            priority if (jr == 3'd0) begin
              det_zero <= (diff == '0);
              det_neg  <= diff[57];
            end else if (jr < 3'd4) begin
              t_vec[2'(jr - 3'd1)] <= diff;
            end else begin
              b_vec[2'(jr - 3'd4)] <= diff;
            end
          end
          if (k == 5'd14) begin
            state <= S_NINIT;
          end
          k <= k + 5'd1;
        end
        S_NINIT: begin
          priority if (det_zero) begin
            degen <= 1'b1;
            state <= S_OUT;
          end else if (nv_zero) begin
            degen <= 1'b1;
            vsel  <= 1'b1;
            state <= vsel ? S_OUT : S_NINIT;
          end else begin
            for (int i = 0; i < 3; i++) begin
              m[i]   <= nv_mag[i];
              neg[i] <= nv[i][57] ^ det_neg;
            end
            state <= S_NSHIFT;
          end
        end
        S_NSHIFT: begin
          if (big) begin
            for (int i = 0; i < 3; i++) begin
              m[i] <= m[i] >> 1;
            end
          end else begin
            sum   <= '0;
            k     <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (k != 5'd3) begin
            sq     <= 60'(m[0][29:0]) * 60'(m[0][29:0]);
            m[0]   <= m[1];
            m[1]   <= m[2];
            m[2]   <= m[0];
            neg[0] <= neg[1];
            neg[1] <= neg[2];
            neg[2] <= neg[0];
          end
          if (k != 5'd0) begin
            sum <= sum_add;
          end
          if (k == 5'd3) begin
            x     <= 63'(sum_add);
            r     <= '0;
            bitv  <= 63'(1) << 62;
            k     <= '0;
            state <= S_SQRT;
          end else begin
            k <= k + 5'd1;
          end
        end
        S_SQRT: begin
          if (x >= trial) begin
            x <= x - trial;
            r <= (r >> 1) + bitv;
          end else begin
            r <= r >> 1;
          end
          bitv <= bitv >> 2;
          if (k == 5'd31) begin
            c     <= 2'd0;
            state <= S_DINIT;
          end
          k <= k + 5'd1;
        end
        S_DINIT: begin
          rem   <= 47'({m[0][29:0], 15'b0}) + 47'(r[31:0]);
          dsh   <= {r[31:0], 17'b0};
          q     <= '0;
          k     <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (ge) begin
            rem <= rem - dsh[46:0];
          end
          q   <= qn[15:0];
          dsh <= dsh >> 1;
          k   <= k + 5'd1;
          if (k == 5'd16) begin
            if (vsel) begin
              res_b[c] <= sval;
            end else begin
              res_t[c] <= sval;
            end
            m[0]   <= m[1];
            m[1]   <= m[2];
            m[2]   <= m[0];
            neg[0] <= neg[1];
            neg[1] <= neg[2];
            neg[2] <= neg[0];
            if (c == 2'd2) begin
              vsel  <= 1'b1;
              state <= vsel ? S_OUT : S_NINIT;
            end else begin
              c     <= c + 2'd1;
              state <= S_DINIT;
            end
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign tangent_x   = res_t[0];
  assign tangent_y   = res_t[1];
  assign tangent_z   = res_t[2];
  assign bitangent_x = res_b[0];
  assign bitangent_y = res_b[1];
  assign bitangent_z = res_b[2];
  assign degenerate  = degen;

endmodule
`default_nettype wire

// File: rtl/triangle_tangent_bitangent_top.sv
// Top level of the per-triangle tangent and bitangent unit.
`default_nettype none
// Vertices (Q16.16 position, Q8.16 uv) arrive one request at a time; every
// third vertex closes a triangle and yields one request on the output with the
// unit tangent and bitangent in Q1.14 and a degenerate flag (zero uv
// determinant or a zero-length vector, which then reads as zero). The front
// end takes one vertex per cycle unless a triangle completes while the queue
// is full, and hands each finished triangle to a two-entry queue, so up to
// two triangles can wait while the back end works. The back end is a
// sequencer around one 25x33 multiplier, a 30x30 squarer, a bit-pair square
// root and a restoring divider: a product phase, then per vector a shift
// phase, a squaring phase, a square root and one division per component.
// A zero vector skips its own normalization and a zero determinant finishes
// after the product phase. The result stays on the output until taken; the
// back end then pulls the next triangle from the queue.
module triangle_tangent_bitangent_top import tbt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [23:0] tex_u,
  input  logic signed [23:0] tex_v,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] tangent_x,
  output logic signed [15:0] tangent_y,
  output logic signed [15:0] tangent_z,
  output logic signed [15:0] bitangent_x,
  output logic signed [15:0] bitangent_y,
  output logic signed [15:0] bitangent_z,
  output logic               degenerate
);

  tri_t push_data;
  tri_t pop_data;
  logic push, full, q_valid, q_pop;

  // collect corners, push a triangle on the third
  tbt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .tex_u     (tex_u),
    .tex_v     (tex_v),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  // decouple vertex intake from the arithmetic
  tbt_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .valid     (q_valid),
    .pop       (q_pop),
    .pop_data  (pop_data)
  );

  // compute and hold the result until taken
  tbt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_data      (pop_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .tangent_x   (tangent_x),
    .tangent_y   (tangent_y),
    .tangent_z   (tangent_z),
    .bitangent_x (bitangent_x),
    .bitangent_y (bitangent_y),
    .bitangent_z (bitangent_z),
    .degenerate  (degenerate)
  );

`ifndef SYNTH
  // intake only backs up when a triangle cannot enter the queue
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> full)
    else $error("input stalled with room in the queue");

  // never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue overflow");

  // a non-degenerate result carries a nonzero tangent
  a_tangent_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !degenerate) |->
      (tangent_x != 16'sd0 || tangent_y != 16'sd0 || tangent_z != 16'sd0))
    else $error("zero tangent without degenerate flag");
`endif

endmodule
`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench for the per-triangle tangent and bitangent unit.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import tbt_pkg::*;

  // Vertex request as queued for the driver
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [23:0] u;
    logic signed [23:0] v;
  } vertex_t;

  // Expected frame result: tangent, bitangent, degenerate flag
  typedef struct packed {
    logic signed [15:0] tx, ty, tz;
    logic signed [15:0] bx, by, bz;
    logic               degen;
  } frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [23:0] tex_u = '0, tex_v = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] tangent_x, tangent_y, tangent_z;
  logic signed [15:0] bitangent_x, bitangent_y, bitangent_z;
  logic degenerate;

  triangle_tangent_bitangent_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .tex_u(tex_u), .tex_v(tex_v),
    .out_valid(out_valid), .out_stall(out_stall),
    .tangent_x(tangent_x), .tangent_y(tangent_y), .tangent_z(tangent_z),
    .bitangent_x(bitangent_x), .bitangent_y(bitangent_y), .bitangent_z(bitangent_z),
    .degenerate(degenerate)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  vertex_t pending_vertices[$];
  frame_t  expected_frames[$];

  // Predictor state: two held corners and the corner count
  vertex_t held_corner[2];
  int      corners_held = 0;

  int errors = 0;
  int vertices_sent = 0;
  int frames_checked = 0;
  int degenerate_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_sender = 1'b0;
  int quiet_cycles = 0;

  // Queue one vertex for the driver
  function automatic void add_vertex(vertex_t vx);
    pending_vertices.insert(pending_vertices.size(), vx);
  endfunction

  // Integer square root, floor
  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Scale a 64-bit vector to a Q1.14 unit vector; returns 0 for a zero vector
  function automatic bit unit_vector(input longint vec[3], output logic signed [15:0] q[3]);
    longint unsigned mag[3];
    longint unsigned mx, sum, len, r;
    int sh;
    mx = 0;
    sum = 0;
    sh = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = vec[i] < 0 ? 64'd0 - longint'(vec[i]) : vec[i];
      if (mag[i] > mx) mx = mag[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) q[i] = '0;
      return 1'b0;
    end
    while ((mx >> sh) >= (64'd1 << 30)) sh++;
    for (int i = 0; i < 3; i++) begin
      mag[i] >>= sh;
      sum += mag[i] * mag[i];
    end
    len = floor_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      r = (mag[i] * (2 * OneQ14) + len) / (2 * len);
      if (r > OneQ14) r = OneQ14;
      q[i] = vec[i] < 0 ? -16'(r) : 16'(r);
    end
    return 1'b1;
  endfunction

  // Advance the corner predictor by one accepted vertex
  function automatic void take_vertex(vertex_t vx);
    longint e1[3], e2[3], tv[3], bv[3];
    longint du1, du2, dv1, dv2, det;
    logic signed [15:0] tq[3], bq[3];
    frame_t f;
    bit degen;
    if (corners_held < 2) begin
      held_corner[corners_held] = vx;
      corners_held++;
      return;
    end
    corners_held = 0;
    e1[0] = longint'(held_corner[1].px) - longint'(held_corner[0].px);
    e1[1] = longint'(held_corner[1].py) - longint'(held_corner[0].py);
    e1[2] = longint'(held_corner[1].pz) - longint'(held_corner[0].pz);
    e2[0] = longint'(vx.px) - longint'(held_corner[0].px);
    e2[1] = longint'(vx.py) - longint'(held_corner[0].py);
    e2[2] = longint'(vx.pz) - longint'(held_corner[0].pz);
    du1 = longint'(held_corner[1].u) - longint'(held_corner[0].u);
    du2 = longint'(vx.u) - longint'(held_corner[0].u);
    // v deltas are negated
    dv1 = longint'(held_corner[0].v) - longint'(held_corner[1].v);
    dv2 = longint'(held_corner[0].v) - longint'(vx.v);
    det = du1 * dv2 - du2 * dv1;
    degen = 1'b0;
    if (det == 0) begin
      degen = 1'b1;
      for (int i = 0; i < 3; i++) begin
        tq[i] = '0;
        bq[i] = '0;
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        tv[i] = dv2 * e1[i] - dv1 * e2[i];
        bv[i] = du1 * e2[i] - du2 * e1[i];
        if (det < 0) begin
          tv[i] = -tv[i];
          bv[i] = -bv[i];
        end
      end
      if (!unit_vector(tv, tq)) degen = 1'b1;
      if (!unit_vector(bv, bq)) degen = 1'b1;
    end
    f.tx = tq[0]; f.ty = tq[1]; f.tz = tq[2];
    f.bx = bq[0]; f.by = bq[1]; f.bz = bq[2];
    f.degen = degen;
    expected_frames.insert(expected_frames.size(), f);
  endfunction

  // Driver: present the next queued vertex, hold while stalled
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        take_vertex('{pos_x, pos_y, pos_z, tex_u, tex_v});
        vertices_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_vertices.size() > 0 && !hold_sender &&
            $urandom_range(99) >= send_idle_pct) begin
          vertex_t vx;
          vx = pending_vertices.pop_front();
          in_valid <= 1'b1;
          pos_x <= vx.px; pos_y <= vx.py; pos_z <= vx.pz;
          tex_u <= vx.u; tex_v <= vx.v;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_frames.size() == 0) begin
          $display("%0t: unexpected result T=(%0d,%0d,%0d) B=(%0d,%0d,%0d) degen=%0b",
                   $time, tangent_x, tangent_y, tangent_z,
                   bitangent_x, bitangent_y, bitangent_z, degenerate);
          errors++;
        end else begin
          frame_t exp_f, got;
          exp_f = expected_frames.pop_front();
          got = '{tangent_x, tangent_y, tangent_z,
                  bitangent_x, bitangent_y, bitangent_z, degenerate};
          if (got !== exp_f) begin
            $display("%0t: mismatch expected T=(%0d,%0d,%0d) B=(%0d,%0d,%0d) degen=%0b",
                     $time, exp_f.tx, exp_f.ty, exp_f.tz, exp_f.bx, exp_f.by, exp_f.bz,
                     exp_f.degen);
            $display("%0t:          actual   T=(%0d,%0d,%0d) B=(%0d,%0d,%0d) degen=%0b",
                     $time, got.tx, got.ty, got.tz, got.bx, got.by, got.bz, got.degen);
            errors++;
          end
          if (exp_f.degen) degenerate_seen++;
          frames_checked++;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: abort after a long stretch with no request moving
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 40000) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 expected_frames.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
      2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
    endcase
  endfunction

  function automatic logic [23:0] rand_tex();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($urandom_range(1 << 17));
      2: return 24'($signed($urandom_range(64)) - 32);
      default: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
    endcase
  endfunction

  function automatic vertex_t rand_vertex();
    return '{rand_coord(), rand_coord(), rand_coord(), rand_tex(), rand_tex()};
  endfunction

  // Wait until the queue is drained and every expected result has come
  task automatic drain();
    while (pending_vertices.size() > 0 || in_valid || expected_frames.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    vertex_t a, b, c;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: a plain right triangle with unit uv
    add_vertex('{32'd0, 32'd0, 32'd0, 24'd0, 24'd0});
    add_vertex('{32'h10000, 32'd0, 32'd0, 24'h10000, 24'd0});
    add_vertex('{32'd0, 32'h10000, 32'd0, 24'd0, 24'h10000});
    // Zero determinant: all uv equal
    add_vertex('{32'd5, 32'd7, 32'd9, 24'd3, 24'd3});
    add_vertex('{32'd1, 32'd2, 32'd3, 24'd3, 24'd3});
    add_vertex('{32'd8, 32'd1, 32'd4, 24'd3, 24'd3});
    // Nonzero determinant but collapsed positions: both vectors zero
    add_vertex('{32'd100, 32'd100, 32'd100, 24'd0, 24'd0});
    add_vertex('{32'd100, 32'd100, 32'd100, 24'd1, 24'd0});
    add_vertex('{32'd100, 32'd100, 32'd100, 24'd0, 24'd1});
    // Extreme positions and texture coordinates, positive determinant
    add_vertex('{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 24'h800000, 24'h7FFFFF});
    add_vertex('{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 24'h7FFFFF, 24'h7FFFFF});
    add_vertex('{32'h80000000, 32'h80000000, 32'h7FFFFFFF, 24'h800000, 24'h800000});
    // One zero vector: only tangent direction from e1 cancels
    add_vertex('{32'd0, 32'd0, 32'd0, 24'd0, 24'd0});
    add_vertex('{32'd0, 32'd0, 32'd0, 24'd1, 24'd0});
    add_vertex('{32'h30000, 32'h20000, 32'hFFFF0000, 24'd0, 24'd1});
    drain();

    // Random phases: no idling, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 76 : 15) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 76 : 15) : 0;
      for (int t = 0; t < 108; t++) begin
        a = rand_vertex();
        b = rand_vertex();
        c = rand_vertex();
        // Sometimes repeat corners or uv to land on degenerate cases
        case ($urandom_range(9))
          0: begin b.u = a.u; b.v = a.v; c.u = a.u; c.v = a.v; end
          1: begin b.px = a.px; b.py = a.py; b.pz = a.pz; end
          2: begin c.px = a.px; c.py = a.py; c.pz = a.pz; b = c; b.u = 24'(a.u + 1); end
          default: ;
        endcase
        add_vertex(a);
        add_vertex(b);
        add_vertex(c);
      end
      // Pause the sender once until all results are back
      if (ph == 1) begin
        while (pending_vertices.size() > 150) @(posedge clk);
        hold_sender = 1'b1;
        while (in_valid || expected_frames.size() > 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      drain();
    end
    repeat (300) @(posedge clk);

    $display("Sent %0d vertices, checked %0d triangles (%0d degenerate)",
             vertices_sent, frames_checked, degenerate_seen);
    $display("Phases: free flow, sparse sender, heavy output stall, mixed idling");
    if (errors == 0 && expected_frames.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_frames.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
